[hdl/bea_pkg.sv]
`timescale 1ns / 1ps

package bea_pkg;

	// apb register map, byte address 4*index
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_WALL_RADIUS      = 3'd0;
	localparam logic [2:0] REG_FLOOR_LEVEL      = 3'd1;
	localparam logic [2:0] REG_CEILING_LEVEL    = 3'd2;
	localparam logic [2:0] REG_TRIGGER_DISTANCE = 3'd3;
	localparam logic [2:0] REG_REPULSION_GAIN   = 3'd4;

	// square root: 64-bit radicand, two result bits per stage
	localparam int SQ_STAGES = 16;

	typedef struct packed {
		logic [34:0] rem;
		logic [31:0] root;
	} sqrt_st_t;

	// one digit-by-digit square root iteration
	function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] b);
		sqrt_st_t o;
		logic [34:0] r;
		logic [34:0] t;
		r = {s.rem[32:0], b};
		t = {1'b0, s.root, 2'b01};
		if (r >= t) begin
			o.rem  = r - t;
			o.root = {s.root[30:0], 1'b1};
		end else begin
			o.rem  = r;
			o.root = {s.root[30:0], 1'b0};
		end
		return o;
	endfunction

endpackage

[hdl/bea_isqrt.sv]
`timescale 1ns / 1ps

module bea_isqrt import bea_pkg::*; #(
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_i,
	input  logic [63:0]   rad_i,
	input  logic [TW-1:0] tag_i,
	output logic          vld_o,
	output logic [31:0]   root_o,
	output logic [TW-1:0] tag_o
);

	sqrt_st_t      st_s  [SQ_STAGES];
	logic [63:0]   rad_s [SQ_STAGES];
	logic [TW-1:0] tag_s [SQ_STAGES];
	logic          vld_s [SQ_STAGES];

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_st
		sqrt_st_t      s_in;
		logic [63:0]   r_in;
		logic [TW-1:0] t_in;
		logic          v_in;

		if (k == 0) begin : g_first
			assign s_in = '0;
			assign r_in = rad_i;
			assign t_in = tag_i;
			assign v_in = vld_i;
		end else begin : g_next
			assign s_in = st_s[k-1];
			assign r_in = rad_s[k-1];
			assign t_in = tag_s[k-1];
			assign v_in = vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k]  <= sqrt_step(sqrt_step(s_in, r_in[63:62]), r_in[61:60]);
				rad_s[k] <= {r_in[59:0], 4'b0000};
				tag_s[k] <= t_in;
			end
		end
	end

	assign vld_o  = vld_s[SQ_STAGES-1];
	assign root_o = st_s[SQ_STAGES-1].root;
	assign tag_o  = tag_s[SQ_STAGES-1];

endmodule

[hdl/bea_div.sv]
`timescale 1ns / 1ps

module bea_div #(
	parameter int LANES = 3,
	parameter int TW    = 1,
	parameter int NW    = 47,
	parameter int DW    = 48,
	parameter int QW    = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       vld_i,
	input  logic [LANES-1:0][NW-1:0]   num_i,
	input  logic [LANES-1:0][DW-1:0]   den_i,
	input  logic [TW-1:0]              tag_i,
	output logic                       vld_o,
	output logic [LANES-1:0][QW-1:0]   q_o,
	output logic [TW-1:0]              tag_o
);

	// restoring division, two quotient bits per stage (one in the last if QW
	// is odd); numerator top bits (above the quotient) must be below the divisor
	localparam int NST = (QW + 1) / 2;

	logic [LANES-1:0][DW-1:0] rem_s [NST];
	logic [LANES-1:0][DW-1:0] den_s [NST];
	logic [LANES-1:0][QW-1:0] q_s   [NST];
	logic [LANES-1:0][QW-1:0] lo_s  [NST];
	logic [TW-1:0]            tag_s [NST];
	logic                     vld_s [NST];

	for (genvar k = 0; k < NST; k++) begin : g_st
		localparam int ITK = (QW - 2 * k >= 2) ? 2 : 1;

		logic [LANES-1:0][DW-1:0] r_in, den_in, r_nx;
		logic [LANES-1:0][QW-1:0] q_in, lo_in, q_nx, lo_nx;
		logic [TW-1:0]            t_in;
		logic                     v_in;
		logic [DW:0]              sh;

		if (k == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					r_in[l]  = DW'(num_i[l][NW-1:QW]);
					lo_in[l] = num_i[l][QW-1:0];
				end
			end
			assign q_in   = '0;
			assign den_in = den_i;
			assign t_in   = tag_i;
			assign v_in   = vld_i;
		end else begin : g_next
			assign r_in   = rem_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign q_in   = q_s[k-1];
			assign den_in = den_s[k-1];
			assign t_in   = tag_s[k-1];
			assign v_in   = vld_s[k-1];
		end

		always_comb begin
			r_nx  = r_in;
			q_nx  = q_in;
			lo_nx = lo_in;
			sh    = '0;
			for (int l = 0; l < LANES; l++) begin
				for (int t = 0; t < ITK; t++) begin
					sh       = {r_nx[l], lo_nx[l][QW-1]};
					lo_nx[l] = {lo_nx[l][QW-2:0], 1'b0};
					if (sh >= {1'b0, den_in[l]}) begin
						sh      = sh - {1'b0, den_in[l]};
						q_nx[l] = {q_nx[l][QW-2:0], 1'b1};
					end else begin
						q_nx[l] = {q_nx[l][QW-2:0], 1'b0};
					end
					r_nx[l] = sh[DW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= r_nx;
				den_s[k] <= den_in;
				q_s[k]   <= q_nx;
				lo_s[k]  <= lo_nx;
				tag_s[k] <= t_in;
			end
		end
	end

	assign vld_o = vld_s[NST-1];
	assign q_o   = q_s[NST-1];
	assign tag_o = tag_s[NST-1];

endmodule

[hdl/boid_environment_avoidance_top.sv]
`timescale 1ns / 1ps

// Boundary avoidance steering for one agent per item. The block takes an
// agent's position, heading and steering vector (signed Q16.16), adds a
// repulsion gain/(d*d+eps) for each of the cylindrical wall, floor and ceiling
// whose distance d is below trigger_distance, subtracts the heading and
// returns the unit-length result plus a flag for the all-zero vector. One item
// is taken every clock cycle while the output is not stalled; the pipeline is
// 73 registers deep. Its depth is set by the two 16-stage square root
// pipelines and the two long dividers (16 and 9 stages), which resolve two
// result bits per stage, but one in the last stage of each divider. A stall
// on the output freezes the whole pipeline, so nothing is dropped or repeated.
// The user must write registers over the apb port only while no item is in
// flight; the block itself does not enforce this.

module boid_environment_avoidance_top import bea_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// apb configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// input items
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic signed [18:0]  head_x,
	input  logic signed [18:0]  head_y,
	input  logic signed [18:0]  head_z,
	input  logic signed [31:0]  acc_x,
	input  logic signed [31:0]  acc_y,
	input  logic signed [31:0]  acc_z,
	// result items
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [17:0]  out_x,
	output logic signed [17:0]  out_y,
	output logic signed [17:0]  out_z,
	output logic                zero_vector
);

	// payload carried alongside the arithmetic
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] pz;
		logic signed [31:0] acx;
		logic signed [31:0] acy;
		logic signed [31:0] acz;
		logic signed [18:0] hdx;
		logic signed [18:0] hdy;
		logic signed [18:0] hdz;
	} cmn_t;

	typedef struct packed {
		cmn_t        c;
		logic        hf;
		logic        hc;
		logic [63:0] af2;
		logic [63:0] ac2;
	} sq1_tag_t;

	// lane 0 wall, lane 1 floor, lane 2 ceiling
	typedef struct packed {
		cmn_t       c;
		logic [2:0] hit;
		logic [2:0] sat;
	} dv1_tag_t;

	typedef struct packed {
		logic [2:0][30:0] nm;
		logic [2:0]       neg;
		logic             zero;
	} sq2_tag_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} dv2_tag_t;

	logic en;

	// ---------------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------------
	logic [30:0]        wall_radius_q;
	logic signed [31:0] floor_level_q;
	logic signed [31:0] ceiling_level_q;
	logic [30:0]        trigger_distance_q;
	logic [30:0]        repulsion_gain_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_radius_q      <= '0;
			floor_level_q      <= '0;
			ceiling_level_q    <= '0;
			trigger_distance_q <= '0;
			repulsion_gain_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_WALL_RADIUS:      wall_radius_q      <= pwdata[30:0];
				REG_FLOOR_LEVEL:      floor_level_q      <= pwdata;
				REG_CEILING_LEVEL:    ceiling_level_q    <= pwdata;
				REG_TRIGGER_DISTANCE: trigger_distance_q <= pwdata[30:0];
				REG_REPULSION_GAIN:   repulsion_gain_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WALL_RADIUS:      prdata = {1'b0, wall_radius_q};
			REG_FLOOR_LEVEL:      prdata = floor_level_q;
			REG_CEILING_LEVEL:    prdata = ceiling_level_q;
			REG_TRIGGER_DISTANCE: prdata = {1'b0, trigger_distance_q};
			REG_REPULSION_GAIN:   prdata = {1'b0, repulsion_gain_q};
			default:              prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// flow control: whole pipeline moves unless a held result is stalled
	// ---------------------------------------------------------------------
	logic out_valid_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// ---------------------------------------------------------------------
	// s1: floor / ceiling distances, trigger tests, absolute values
	// ---------------------------------------------------------------------
	logic signed [32:0] df_c, dc_c;
	logic               vld_s1;
	cmn_t               cm_s1;
	logic [31:0]        abx_s1, abz_s1, abf_s1, abc_s1;
	logic               hf_s1, hc_s1;

	assign df_c = {pos_y[31], pos_y} - {floor_level_q[31], floor_level_q};
	assign dc_c = {ceiling_level_q[31], ceiling_level_q} - {pos_y[31], pos_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s1.px  <= pos_x;
			cm_s1.pz  <= pos_z;
			cm_s1.acx <= acc_x;
			cm_s1.acy <= acc_y;
			cm_s1.acz <= acc_z;
			cm_s1.hdx <= head_x;
			cm_s1.hdy <= head_y;
			cm_s1.hdz <= head_z;
			abx_s1    <= pos_x[31] ? (~pos_x + 32'd1) : pos_x;
			abz_s1    <= pos_z[31] ? (~pos_z + 32'd1) : pos_z;
			abf_s1    <= df_c[32] ? 32'(-df_c) : df_c[31:0];
			abc_s1    <= dc_c[32] ? 32'(-dc_c) : dc_c[31:0];
			hf_s1     <= df_c < $signed({2'b00, trigger_distance_q});
			hc_s1     <= dc_c < $signed({2'b00, trigger_distance_q});
		end
	end

	// ---------------------------------------------------------------------
	// s2: squares
	// ---------------------------------------------------------------------
	logic        vld_s2;
	cmn_t        cm_s2;
	logic [63:0] sqx_s2, sqz_s2, af2_s2, ac2_s2;
	logic        hf_s2, hc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s2  <= cm_s1;
			sqx_s2 <= 64'(abx_s1) * 64'(abx_s1);
			sqz_s2 <= 64'(abz_s1) * 64'(abz_s1);
			af2_s2 <= 64'(abf_s1) * 64'(abf_s1);
			ac2_s2 <= 64'(abc_s1) * 64'(abc_s1);
			hf_s2  <= hf_s1;
			hc_s2  <= hc_s1;
		end
	end

	// ---------------------------------------------------------------------
	// s3: xz radius squared, then root in the first sqrt pipeline
	// ---------------------------------------------------------------------
	logic        vld_s3;
	logic [63:0] rad_s3;
	sq1_tag_t    t_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3    <= sqx_s2 + sqz_s2;
			t_s3.c    <= cm_s2;
			t_s3.hf   <= hf_s2;
			t_s3.hc   <= hc_s2;
			t_s3.af2  <= af2_s2;
			t_s3.ac2  <= ac2_s2;
		end
	end

	logic                      sq1_vld;
	logic [31:0]               sq1_root;
	logic [$bits(sq1_tag_t)-1:0] sq1_tag;
	sq1_tag_t                  sq1_t;

	bea_isqrt #(
		.TW($bits(sq1_tag_t))
	) u_sqrt_rad (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s3),
		.rad_i  (rad_s3),
		.tag_i  (t_s3),
		.vld_o  (sq1_vld),
		.root_o (sq1_root),
		.tag_o  (sq1_tag)
	);

	assign sq1_t = sq1_tag;

	// ---------------------------------------------------------------------
	// s4: wall distance and its trigger test
	// ---------------------------------------------------------------------
	logic signed [33:0] dw_c;
	logic               vld_s4;
	sq1_tag_t           t_s4;
	logic [31:0]        abw_s4;
	logic               hw_s4;

	assign dw_c = {3'b000, wall_radius_q} - {2'b00, sq1_root};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4   <= sq1_t;
			abw_s4 <= dw_c[33] ? 32'(-dw_c) : dw_c[31:0];
			hw_s4  <= dw_c < $signed({3'b000, trigger_distance_q});
		end
	end

	// ---------------------------------------------------------------------
	// s5: wall distance squared
	// ---------------------------------------------------------------------
	logic        vld_s5;
	sq1_tag_t    t_s5;
	logic [63:0] aw2_s5;
	logic        hw_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s5   <= t_s4;
			aw2_s5 <= 64'(abw_s4) * 64'(abw_s4);
			hw_s5  <= hw_s4;
		end
	end

	// ---------------------------------------------------------------------
	// s6: denominators d*d/2^16 + 1 and saturation tests
	// quotient overflows 31 bits exactly when den <= gain >> 15
	// ---------------------------------------------------------------------
	logic [2:0][47:0] den_c;
	logic             vld_s6;
	logic [2:0][47:0] den_s6;
	dv1_tag_t         t_s6;

	always_comb begin
		den_c[0] = aw2_s5[63:16] + 48'd1;
		den_c[1] = t_s5.af2[63:16] + 48'd1;
		den_c[2] = t_s5.ac2[63:16] + 48'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6   <= den_c;
			t_s6.c   <= t_s5.c;
			t_s6.hit <= {t_s5.hc, t_s5.hf, hw_s5};
			for (int l = 0; l < 3; l++) begin
				t_s6.sat[l] <= den_c[l] <= {32'd0, repulsion_gain_q[30:15]};
			end
		end
	end

	// strength = gain * 2^16 / den in three lanes
	logic [2:0][46:0]              num1_c;
	logic                          dv1_vld;
	logic [2:0][30:0]              dv1_q;
	logic [$bits(dv1_tag_t)-1:0]   dv1_tag;
	dv1_tag_t                      dv1_t;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num1_c[l] = {repulsion_gain_q, 16'd0};
		end
	end

	bea_div #(
		.LANES (3),
		.TW    ($bits(dv1_tag_t)),
		.NW    (47),
		.DW    (48),
		.QW    (31)
	) u_div_strength (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s6),
		.num_i  (num1_c),
		.den_i  (den_s6),
		.tag_i  (t_s6),
		.vld_o  (dv1_vld),
		.q_o    (dv1_q),
		.tag_o  (dv1_tag)
	);

	assign dv1_t = dv1_tag;

	// ---------------------------------------------------------------------
	// s7: saturate strengths, wall products, y component
	// ---------------------------------------------------------------------
	logic [2:0][30:0]   str_c;
	logic signed [47:0] vy_c;
	logic               vld_s7;
	cmn_t               cm_s7;
	logic               hw_s7;
	logic signed [63:0] pwx_s7, pwz_s7;
	logic signed [47:0] vy_s7;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			str_c[l] = dv1_t.sat[l] ? 31'h7FFF_FFFF : dv1_q[l];
		end
		vy_c = 48'(dv1_t.c.acy) - 48'(dv1_t.c.hdy);
		if (dv1_t.hit[1]) begin
			vy_c = vy_c + $signed(48'(str_c[1]));
		end
		if (dv1_t.hit[2]) begin
			vy_c = vy_c - $signed(48'(str_c[2]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= dv1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cm_s7  <= dv1_t.c;
			hw_s7  <= dv1_t.hit[0];
			pwx_s7 <= 64'(dv1_t.c.px) * 64'($signed({1'b0, str_c[0]}));
			pwz_s7 <= 64'(dv1_t.c.pz) * 64'($signed({1'b0, str_c[0]}));
			vy_s7  <= vy_c;
		end
	end

	// ---------------------------------------------------------------------
	// s8: x and z components, wall term rounded toward minus infinity
	// ---------------------------------------------------------------------
	logic signed [47:0] vx_c, vz_c;
	logic               vld_s8;
	logic signed [47:0] vx_s8, vy_s8, vz_s8;

	always_comb begin
		vx_c = 48'(cm_s7.acx) - 48'(cm_s7.hdx);
		vz_c = 48'(cm_s7.acz) - 48'(cm_s7.hdz);
		if (hw_s7) begin
			vx_c = vx_c - $signed(pwx_s7[63:16]);
			vz_c = vz_c - $signed(pwz_s7[63:16]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s8 <= vx_c;
			vy_s8 <= vy_s7;
			vz_s8 <= vz_c;
		end
	end

	// ---------------------------------------------------------------------
	// s9: magnitudes, signs, zero test
	// ---------------------------------------------------------------------
	logic             vld_s9;
	logic [2:0][46:0] mag_s9;
	logic [2:0]       neg_s9;
	logic             zero_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s9[0] <= vx_s8[47] ? 47'(-vx_s8) : vx_s8[46:0];
			mag_s9[1] <= vy_s8[47] ? 47'(-vy_s8) : vy_s8[46:0];
			mag_s9[2] <= vz_s8[47] ? 47'(-vz_s8) : vz_s8[46:0];
			neg_s9    <= {vz_s8[47], vy_s8[47], vx_s8[47]};
			zero_s9   <= (vx_s8 == '0) && (vy_s8 == '0) && (vz_s8 == '0);
		end
	end

	// ---------------------------------------------------------------------
	// s10: largest magnitude
	// ---------------------------------------------------------------------
	logic [46:0]      mx_c;
	logic             vld_s10;
	logic [2:0][46:0] mag_s10;
	logic [46:0]      mx_s10;
	logic [2:0]       neg_s10;
	logic             zero_s10;

	always_comb begin
		mx_c = mag_s9[0];
		if (mag_s9[1] > mx_c) begin
			mx_c = mag_s9[1];
		end
		if (mag_s9[2] > mx_c) begin
			mx_c = mag_s9[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s10  <= mag_s9;
			mx_s10   <= mx_c;
			neg_s10  <= neg_s9;
			zero_s10 <= zero_s9;
		end
	end

	// ---------------------------------------------------------------------
	// s11: leading-one search, coarse (which byte)
	// ---------------------------------------------------------------------
	logic [47:0]      mx48_c;
	logic [2:0]       grp_c;
	logic             vld_s11;
	logic [2:0][46:0] mag_s11;
	logic [2:0]       grp_s11;
	logic [7:0]       byt_s11;
	logic [2:0]       neg_s11;
	logic             zero_s11;

	assign mx48_c = {1'b0, mx_s10};

	always_comb begin
		grp_c = 3'd0;
		for (int g = 0; g < 6; g++) begin
			if (mx48_c[g*8 +: 8] != 8'd0) begin
				grp_c = 3'(g);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s11  <= mag_s10;
			grp_s11  <= grp_c;
			byt_s11  <= mx48_c[grp_c*8 +: 8];
			neg_s11  <= neg_s10;
			zero_s11 <= zero_s10;
		end
	end

	// ---------------------------------------------------------------------
	// s12: leading-one search, fine (bit inside the byte)
	// ---------------------------------------------------------------------
	logic [2:0]       bit_c;
	logic             vld_s12;
	logic [2:0][46:0] mag_s12;
	logic [5:0]       msb_s12;
	logic [2:0]       neg_s12;
	logic             zero_s12;

	always_comb begin
		bit_c = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (byt_s11[i]) begin
				bit_c = 3'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s12  <= mag_s11;
			msb_s12  <= {grp_s11, bit_c};
			neg_s12  <= neg_s11;
			zero_s12 <= zero_s11;
		end
	end

	// ---------------------------------------------------------------------
	// s13: normalize so the largest magnitude lies in [2^30, 2^31)
	// ---------------------------------------------------------------------
	logic [5:0]       rsh_c, lsh_c;
	logic [2:0][30:0] nm_c;
	logic             vld_s13;
	logic [2:0][30:0] nm_s13;
	logic [2:0]       neg_s13;
	logic             zero_s13;

	assign rsh_c = msb_s12 - 6'd30;
	assign lsh_c = 6'd30 - msb_s12;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (msb_s12 >= 6'd30) begin
				nm_c[l] = 31'(mag_s12[l] >> rsh_c);
			end else begin
				nm_c[l] = 31'(mag_s12[l] << lsh_c);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else if (en) begin
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nm_s13   <= nm_c;
			neg_s13  <= neg_s12;
			zero_s13 <= zero_s12;
		end
	end

	// ---------------------------------------------------------------------
	// s14: component squares
	// ---------------------------------------------------------------------
	logic             vld_s14;
	logic [2:0][61:0] nsq_s14;
	sq2_tag_t         t_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s14 <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				nsq_s14[l] <= 62'(nm_s13[l]) * 62'(nm_s13[l]);
			end
			t_s14.nm   <= nm_s13;
			t_s14.neg  <= neg_s13;
			t_s14.zero <= zero_s13;
		end
	end

	// ---------------------------------------------------------------------
	// s15: sum of squares, then length in the second sqrt pipeline
	// ---------------------------------------------------------------------
	logic        vld_s15;
	logic [63:0] nsum_s15;
	sq2_tag_t    t_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
		end else if (en) begin
			vld_s15 <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nsum_s15 <= 64'(nsq_s14[0]) + 64'(nsq_s14[1]) + 64'(nsq_s14[2]);
			t_s15    <= t_s14;
		end
	end

	logic                        sq2_vld;
	logic [31:0]                 sq2_root;
	logic [$bits(sq2_tag_t)-1:0] sq2_tag;
	sq2_tag_t                    sq2_t;

	bea_isqrt #(
		.TW($bits(sq2_tag_t))
	) u_sqrt_len (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s15),
		.rad_i  (nsum_s15),
		.tag_i  (t_s15),
		.vld_o  (sq2_vld),
		.root_o (sq2_root),
		.tag_o  (sq2_tag)
	);

	assign sq2_t = sq2_tag;

	// each component * 2^16 / length, at most 65536
	logic [2:0][46:0]            num2_c;
	logic [2:0][31:0]            den2_c;
	dv2_tag_t                    t2_c;
	logic                        dv2_vld;
	logic [2:0][16:0]            dv2_q;
	logic [$bits(dv2_tag_t)-1:0] dv2_tag;
	dv2_tag_t                    dv2_t;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			num2_c[l] = {sq2_t.nm[l], 16'd0};
			den2_c[l] = sq2_root;
		end
		t2_c.neg  = sq2_t.neg;
		t2_c.zero = sq2_t.zero;
	end

	bea_div #(
		.LANES (3),
		.TW    ($bits(dv2_tag_t)),
		.NW    (47),
		.DW    (32),
		.QW    (17)
	) u_div_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (sq2_vld),
		.num_i  (num2_c),
		.den_i  (den2_c),
		.tag_i  (t2_c),
		.vld_o  (dv2_vld),
		.q_o    (dv2_q),
		.tag_o  (dv2_tag)
	);

	assign dv2_t = dv2_tag;

	// ---------------------------------------------------------------------
	// output register: signs restored, zero vector forced to zeros
	// ---------------------------------------------------------------------
	logic [2:0][17:0]  res_c;
	logic signed [17:0] out_x_q, out_y_q, out_z_q;
	logic               zero_vector_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (dv2_t.zero) begin
				res_c[l] = '0;
			end else if (dv2_t.neg[l]) begin
				res_c[l] = 18'(-{1'b0, dv2_q[l]});
			end else begin
				res_c[l] = {1'b0, dv2_q[l]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_x_q       <= res_c[0];
			out_y_q       <= res_c[1];
			out_z_q       <= res_c[2];
			zero_vector_q <= dv2_t.zero;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_x       = out_x_q;
	assign out_y       = out_y_q;
	assign out_z       = out_z_q;
	assign zero_vector = zero_vector_q;

endmodule
